/* hdl/dsp_pkg.sv */
// Shared types, constants and a helper function for the date-time string parser.
`default_nettype none

package dsp_pkg;

  // String layout.
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [POS_W-1:0] POS_YEAR_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_DASH1   = 4'd4;
  localparam logic [POS_W-1:0] POS_DASH2   = 4'd7;
  localparam logic [POS_W-1:0] POS_SLASH   = 4'd10;
  localparam logic [POS_W-1:0] POS_COLON   = 4'd13;
  localparam logic [POS_W-1:0] POS_LAST    = 4'd15;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Field widths.
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned ACC_W    = 7;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned OUT_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;
  localparam int unsigned OUT_PAD  = ((OUT_W + 7) / 8) * 8 - OUT_W;
  localparam int unsigned TDATA_W  = OUT_W + OUT_PAD;

  // Calendar limits.
  localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd1000;
  localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
  localparam logic [ACC_W-1:0]  MONTH_MIN  = 7'd1;
  localparam logic [ACC_W-1:0]  MONTH_MAX  = 7'd12;
  localparam logic [ACC_W-1:0]  DAY_MIN    = 7'd1;
  localparam logic [ACC_W-1:0]  HOUR_MAX   = 7'd23;
  localparam logic [ACC_W-1:0]  MINUTE_MAX = 7'd59;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Which accumulator a byte feeds.
  typedef enum logic [2:0] {
    FLD_YEAR_HI,
    FLD_YEAR_LO,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SEP
  } field_e;

  // One classified byte, passed from front to back.
  typedef struct packed {
    logic               first;
    logic               last;
    logic               bad;
    field_e             field;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  // Length of a month; zero for a month code outside 1..12.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] days;
    days = '0;
    case (month) inside
      4'd2:                                  days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               days = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      default:                               days = '0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

/* hdl/dsp_front.sv */
// Front end: accepts bytes, tracks the position and classifies each byte.
`default_nettype none

module dsp_front import dsp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_code
  input  wire logic              s_axis_tuser,   // [0] first
  output logic                   push_o,
  input  wire logic              push_ready_i,
  output token_t                 token_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  pos;
  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] ch_off;
  logic              is_digit;
  logic              accept;

  assign ch       = s_axis_tdata;
  assign ch_off   = ch - CH_ZERO;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign accept   = s_axis_tvalid && push_ready_i;

  assign s_axis_tready = push_ready_i;
  assign push_o        = s_axis_tvalid;

  // A start flag restarts the string at position zero.
  assign pos   = s_axis_tuser ? '0 : pos_q;
  assign pos_d = pos + 1'b1;

  // Classify the byte by its position in the string.
  always_comb begin
    token_o.first = s_axis_tuser;
    token_o.last  = (pos == POS_LAST);
    token_o.digit = ch_off[DIGIT_W-1:0];
    token_o.bad   = 1'b0;
    token_o.field = FLD_SEP;
    case (pos) inside
      POS_DASH1, POS_DASH2: begin
        token_o.bad = (ch != CH_DASH);
      end
      POS_SLASH: begin
        token_o.bad = (ch != CH_SLASH);
      end
      POS_COLON: begin
        token_o.bad = (ch != CH_COLON);
      end
      default: begin
        token_o.bad = !is_digit;
        if (pos < POS_YEAR_LO) begin
          token_o.field = FLD_YEAR_HI;
        end else if (pos < POS_DASH1) begin
          token_o.field = FLD_YEAR_LO;
        end else if (pos < POS_DASH2) begin
          token_o.field = FLD_MONTH;
        end else if (pos < POS_SLASH) begin
          token_o.field = FLD_DAY;
        end else if (pos < POS_COLON) begin
          token_o.field = FLD_HOUR;
        end else begin
          token_o.field = FLD_MINUTE;
        end
      end
    endcase
  end

  // Position advances on every accepted byte and wraps after the sixteenth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/dsp_queue.sv */
// Short queue of classified bytes between the front and back ends.
`default_nettype none

module dsp_queue import dsp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  output logic        push_ready_o,
  input  wire token_t token_i,
  output logic        pop_valid_o,
  input  wire logic   pop_i,
  output token_t      token_o
);

  token_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign token_o      = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= token_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/dsp_back.sv */
// Back end: accumulates the decimal fields, checks the calendar and holds the result.
`default_nettype none

module dsp_back import dsp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               tok_valid_i,
  input  wire token_t             token_i,
  output logic                    pop_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,  // [13:0] year, [17:14] month, [22:18] day,
                                                 // [27:23] hour, [33:28] minute, zero pad
  output logic                    m_axis_tuser   // [0] valid_res
);

  logic              err_q, err_d, err_b;
  logic [YEAR_W-1:0] year_q, year_d, year_b;
  logic [ACC_W-1:0]  yhi_q, yhi_d, yhi_b;
  logic [ACC_W-1:0]  ylo_q, ylo_d, ylo_b;
  logic [ACC_W-1:0]  month_q, month_d, month_b;
  logic [ACC_W-1:0]  day_q, day_d, day_b;
  logic [ACC_W-1:0]  hour_q, hour_d, hour_b;
  logic [ACC_W-1:0]  minute_q, minute_d, minute_b;

  logic                  leap;
  logic [DAY_W-1:0]      dim;
  logic                  cal_ok;
  logic                  pop;
  logic [YEAR_W+3:0]     year_sum;

  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [YEAR_W-1:0]     out_year_q;
  logic [MONTH_W-1:0]    out_month_q;
  logic [DAY_W-1:0]      out_day_q;
  logic [HOUR_W-1:0]     out_hour_q;
  logic [MINUTE_W-1:0]   out_minute_q;

  // Decimal shift-in of one digit on a narrow accumulator.
  function automatic logic [ACC_W-1:0] shift_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [DIGIT_W-1:0] dig);
    logic [ACC_W+3:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, dig};
    return sum[ACC_W-1:0];
  endfunction

  // The last byte leaves only when the output register can take the result.
  assign pop   = tok_valid_i && (!token_i.last || !out_valid_q || m_axis_tready);
  assign pop_o = pop;

  // A start flag clears the string before its first byte is applied.
  always_comb begin
    if (token_i.first) begin
      err_b    = 1'b0;
      year_b   = '0;
      yhi_b    = '0;
      ylo_b    = '0;
      month_b  = '0;
      day_b    = '0;
      hour_b   = '0;
      minute_b = '0;
    end else begin
      err_b    = err_q;
      year_b   = year_q;
      yhi_b    = yhi_q;
      ylo_b    = ylo_q;
      month_b  = month_q;
      day_b    = day_q;
      hour_b   = hour_q;
      minute_b = minute_q;
    end
  end

  assign year_sum = {1'b0, year_b, 3'b000} + {3'b000, year_b, 1'b0}
                  + {{(YEAR_W){1'b0}}, token_i.digit};

  // Apply the byte: flag a format error or shift its digit into the field.
  always_comb begin
    err_d    = err_b | token_i.bad;
    year_d   = year_b;
    yhi_d    = yhi_b;
    ylo_d    = ylo_b;
    month_d  = month_b;
    day_d    = day_b;
    hour_d   = hour_b;
    minute_d = minute_b;
    if (!token_i.bad) begin
      case (token_i.field)
        FLD_YEAR_HI: begin
          year_d = year_sum[YEAR_W-1:0];
          yhi_d  = shift_digit(yhi_b, token_i.digit);
        end
        FLD_YEAR_LO: begin
          year_d = year_sum[YEAR_W-1:0];
          ylo_d  = shift_digit(ylo_b, token_i.digit);
        end
        FLD_MONTH:  month_d  = shift_digit(month_b, token_i.digit);
        FLD_DAY:    day_d    = shift_digit(day_b, token_i.digit);
        FLD_HOUR:   hour_d   = shift_digit(hour_b, token_i.digit);
        FLD_MINUTE: minute_d = shift_digit(minute_b, token_i.digit);
        default:    err_d    = err_b | token_i.bad;
      endcase
    end
  end

  // Leap year from the century digits and the last two digits of the year:
  // a year not ending in 00 is leap when those two digits divide by four,
  // a century year when its century digits do.
  assign leap = (ylo_d != '0) ? (ylo_d[1:0] == 2'b00) : (yhi_d[1:0] == 2'b00);
  assign dim  = month_days(month_d[MONTH_W-1:0], leap);

  assign cal_ok = !err_d
               && (year_d >= YEAR_MIN) && (year_d <= YEAR_MAX)
               && (month_d >= MONTH_MIN) && (month_d <= MONTH_MAX)
               && (hour_d <= HOUR_MAX) && (minute_d <= MINUTE_MAX)
               && (day_d >= DAY_MIN) && (day_d <= {2'b00, dim});

  // String state; cleared after the sixteenth byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q    <= 1'b0;
      year_q   <= '0;
      yhi_q    <= '0;
      ylo_q    <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
    end else if (pop) begin
      if (token_i.last) begin
        err_q    <= 1'b0;
        year_q   <= '0;
        yhi_q    <= '0;
        ylo_q    <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
      end else begin
        err_q    <= err_d;
        year_q   <= year_d;
        yhi_q    <= yhi_d;
        ylo_q    <= ylo_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && token_i.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; every field reads zero for an invalid string.
  always_ff @(posedge clk_i) begin
    if (pop && token_i.last) begin
      out_ok_q     <= cal_ok;
      out_year_q   <= cal_ok ? year_d : '0;
      out_month_q  <= cal_ok ? month_d[MONTH_W-1:0] : '0;
      out_day_q    <= cal_ok ? day_d[DAY_W-1:0] : '0;
      out_hour_q   <= cal_ok ? hour_d[HOUR_W-1:0] : '0;
      out_minute_q <= cal_ok ? minute_d[MINUTE_W-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_minute_q, out_hour_q, out_day_q,
                          out_month_q, out_year_q};

endmodule

`default_nettype wire

/* hdl/date_string_parser_top.sv */
// Top level of the date-time string parser: front end, queue and back end.
// Path: the sixteenth byte of a string is first held in the queue register, and
// its result is then captured in the output register on the master side.
// Throughput: one byte per cycle while the queue has room for it.
// Reset: rst_ni clears the position, the queue and the accumulators at once;
// bytes are taken as soon as reset is released.
`default_nettype none

module date_string_parser_top import dsp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic               s_axis_tuser,   // [0] first
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // [13:0] year, [17:14] month, [22:18] day,
                                                  // [27:23] hour, [33:28] minute, zero pad
  output logic                    m_axis_tuser    // [0] valid_res
);

  logic   push;
  logic   push_ready;
  token_t push_token;
  logic   tok_valid;
  logic   pop;
  token_t pop_token;

  // Classify incoming bytes.
  dsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .token_o       (push_token)
  );

  // Decouple front and back.
  dsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .token_i      (push_token),
    .pop_valid_o  (tok_valid),
    .pop_i        (pop),
    .token_o      (pop_token)
  );

  // Accumulate, check and deliver results.
  dsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (tok_valid),
    .token_i       (pop_token),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* tb/sv/date_string_checker.sv */
// Checker for the date-time string parser: predicts every result and compares it.
`timescale 1ns / 100ps

module date_string_checker import dsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [CHAR_W-1:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic               s_axis_tuser_i,   // [0] first
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [TDATA_W-1:0] m_axis_tdata_i,   // [13:0] year, [17:14] month, [22:18] day,
                                               // [27:23] hour, [33:28] minute, zero pad
  input  logic               m_axis_tuser_i,   // [0] valid_res
  output int                 mismatches_o,
  output int                 pending_o
);

  // One parsed date as the block reports it.
  typedef struct packed {
    logic                valid_res;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } date_fields_t;

  localparam int MONTH_LEN [13] = '{0, 31, 0, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Parser state, mirrored from the block.
  logic [POS_W-1:0]  text_pos   = '0;
  logic              bad_format = 1'b0;
  logic [YEAR_W-1:0] year_acc   = '0;
  logic [ACC_W-1:0]  month_acc  = '0;
  logic [ACC_W-1:0]  day_acc    = '0;
  logic [ACC_W-1:0]  hour_acc   = '0;
  logic [ACC_W-1:0]  minute_acc = '0;

  date_fields_t expected_dates[$];
  int           mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic clear_parse();
    text_pos   = '0;
    bad_format = 1'b0;
    year_acc   = '0;
    month_acc  = '0;
    day_acc    = '0;
    hour_acc   = '0;
    minute_acc = '0;
  endtask

  // Take one accepted character; the sixteenth one queues an expected date.
  task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic first);
    logic [POS_W-1:0] pos;
    int               digit;
    int               month_len;
    logic             leap;
    logic             ok;
    date_fields_t     date;
    if (first) begin
      clear_parse();
    end
    pos = text_pos;
    if (pos == POS_DASH1 || pos == POS_DASH2) begin
      if (ch != CH_DASH) bad_format = 1'b1;
    end else if (pos == POS_SLASH) begin
      if (ch != CH_SLASH) bad_format = 1'b1;
    end else if (pos == POS_COLON) begin
      if (ch != CH_COLON) bad_format = 1'b1;
    end else if (ch < CH_ZERO || ch > CH_NINE) begin
      bad_format = 1'b1;
    end else begin
      digit = int'(ch) - int'(CH_ZERO);
      if (pos < POS_DASH1) begin
        year_acc = YEAR_W'(int'(year_acc) * 10 + digit);
      end else if (pos < POS_DASH2) begin
        month_acc = ACC_W'(int'(month_acc) * 10 + digit);
      end else if (pos < POS_SLASH) begin
        day_acc = ACC_W'(int'(day_acc) * 10 + digit);
      end else if (pos < POS_COLON) begin
        hour_acc = ACC_W'(int'(hour_acc) * 10 + digit);
      end else begin
        minute_acc = ACC_W'(int'(minute_acc) * 10 + digit);
      end
    end

    if (pos != POS_LAST) begin
      text_pos = pos + 1'b1;
    end else begin
      // Format and calendar checks; February follows the Gregorian leap rule.
      leap = ((year_acc % 4 == 0) && (year_acc % 100 != 0)) || (year_acc % 400 == 0);
      ok = !bad_format && year_acc >= YEAR_MIN && year_acc <= YEAR_MAX &&
           month_acc >= MONTH_MIN && month_acc <= MONTH_MAX &&
           hour_acc <= HOUR_MAX && minute_acc <= MINUTE_MAX;
      if (ok) begin
        month_len = (month_acc == 7'd2) ? (leap ? 29 : 28) : MONTH_LEN[month_acc];
        ok = day_acc >= DAY_MIN && int'(day_acc) <= month_len;
      end
      date = '0;
      if (ok) begin
        date.valid_res = 1'b1;
        date.year      = year_acc;
        date.month     = month_acc[MONTH_W-1:0];
        date.day       = day_acc[DAY_W-1:0];
        date.hour      = hour_acc[HOUR_W-1:0];
        date.minute    = minute_acc[MINUTE_W-1:0];
      end
      expected_dates.push_back(date);
      clear_parse();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare a delivered date with the oldest expected one.
  task automatic check_date();
    date_fields_t want;
    date_fields_t got;
    got.valid_res = m_axis_tuser_i;
    got.year      = m_axis_tdata_i[0 +: YEAR_W];
    got.month     = m_axis_tdata_i[YEAR_W +: MONTH_W];
    got.day       = m_axis_tdata_i[YEAR_W + MONTH_W +: DAY_W];
    got.hour      = m_axis_tdata_i[YEAR_W + MONTH_W + DAY_W +: HOUR_W];
    got.minute    = m_axis_tdata_i[YEAR_W + MONTH_W + DAY_W + HOUR_W +: MINUTE_W];
    if (expected_dates.size() == 0) begin
      $error("unexpected result: valid_res %0b year %0d", got.valid_res, got.year);
      mismatches++;
    end else begin
      want = expected_dates.pop_front();
      compare_field("valid_res", want.valid_res, got.valid_res);
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
    end
  endtask

  // Watch both channels at every rising clock edge out of reset.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_char(s_axis_tdata_i, s_axis_tuser_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_date();
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

/* tb/sv/tb_date_string_parser_top.sv */
// Testbench top for the date-time string parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_date_string_parser_top;
  import dsp_pkg::*;

  localparam int RANDOM_CHARS = 1650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 10;

  typedef logic [CHAR_W-1:0] date_text_t [16];

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [CHAR_W-1:0]  s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;

  int   mismatches;
  int   pending;
  int   sent_count  = 0;
  int   cycle_count = 0;
  logic quiet_phase = 1'b0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  date_string_parser_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  date_string_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: a random stall before each result, and none in the quiet phase.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one character after a random gap and hold it until taken.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic first);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic send_text(input date_text_t text, input int len, input logic first);
    for (int i = 0; i < len; i++) begin
      send_char(text[i], (i == 0) ? first : 1'b0);
    end
  endtask

  // Stop sending until every expected date has been delivered.
  task automatic wait_for_dates();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic date_text_t format_date(input int year, input int month, input int day,
                                             input int hour, input int minute);
    date_text_t text;
    text[0]  = CH_ZERO + CHAR_W'((year / 1000) % 10);
    text[1]  = CH_ZERO + CHAR_W'((year / 100) % 10);
    text[2]  = CH_ZERO + CHAR_W'((year / 10) % 10);
    text[3]  = CH_ZERO + CHAR_W'(year % 10);
    text[4]  = CH_DASH;
    text[5]  = CH_ZERO + CHAR_W'((month / 10) % 10);
    text[6]  = CH_ZERO + CHAR_W'(month % 10);
    text[7]  = CH_DASH;
    text[8]  = CH_ZERO + CHAR_W'((day / 10) % 10);
    text[9]  = CH_ZERO + CHAR_W'(day % 10);
    text[10] = CH_SLASH;
    text[11] = CH_ZERO + CHAR_W'((hour / 10) % 10);
    text[12] = CH_ZERO + CHAR_W'(hour % 10);
    text[13] = CH_COLON;
    text[14] = CH_ZERO + CHAR_W'((minute / 10) % 10);
    text[15] = CH_ZERO + CHAR_W'(minute % 10);
    return text;
  endfunction

  // Mostly in range, with weight on the edges and some two-digit noise.
  function automatic int pick_field(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 99);
      1:       return (lo > 0 && $urandom_range(0, 1) == 1) ? lo - 1 : lo;
      2:       return $urandom_range(hi - 3, hi + 1);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic date_text_t random_date();
    int years [10] = '{0, 999, 1000, 9999, 1900, 2000, 2004, 2100, 2400, 1996};
    int year;
    case ($urandom_range(0, 5))
      0:       year = $urandom_range(0, 9999);
      1, 2:    year = years[$urandom_range(0, 9)];
      default: year = $urandom_range(1000, 9999);
    endcase
    return format_date(year, pick_field(1, 12), pick_field(1, 31),
                       pick_field(0, 23), pick_field(0, 59));
  endfunction

  initial begin
    date_text_t text;
    int         pick;
    int         len;
    logic       force_first;
    logic       paused;
    force_first = 1'b0;
    paused      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a short string with extreme bytes, a leap day with the
    // largest time, then a short string cut off by the random part.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(CH_NINE, 1'b0);
    send_text(format_date(2000, 2, 29, 23, 59), 16, 1'b1);
    send_text(format_date(1900, 2, 29, 0, 0), 3, 1'b1);
    force_first = 1'b1;
    wait_for_dates();

    // Random: mostly whole strings, some cut short, some raw noise.
    while (sent_count < RANDOM_CHARS) begin
      if ($urandom_range(0, 19) == 0) quiet_phase = !quiet_phase;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        text = random_date();
        // Occasionally spoil one character, often with a near-miss code.
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 5))
            0:       text[$urandom_range(0, 15)] = CH_SLASH;
            1:       text[$urandom_range(0, 15)] = CH_COLON;
            2:       text[$urandom_range(0, 15)] = CH_DASH;
            3:       text[$urandom_range(0, 15)] = CH_ZERO;
            default: text[$urandom_range(0, 15)] = CHAR_W'($urandom_range(0, 255));
          endcase
        end
        send_text(text, 16, force_first || ($urandom_range(0, 4) != 0));
        force_first = 1'b0;
      end else if (pick < 85) begin
        len = $urandom_range(1, 15);
        send_text(random_date(), len, 1'b1);
        force_first = 1'b1;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_char(CHAR_W'($urandom_range(0, 255)), force_first || ($urandom_range(0, 1) == 1));
          force_first = 1'b0;
        end
      end
      if (!paused && sent_count >= RANDOM_CHARS / 2) begin
        wait_for_dates();
        paused = 1'b1;
      end
    end

    wait_for_dates();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dsp_pkg.sv
hdl/dsp_front.sv
hdl/dsp_queue.sv
hdl/dsp_back.sv
hdl/date_string_parser_top.sv
tb/sv/date_string_checker.sv
tb/sv/tb_date_string_parser_top.sv
